### rtl/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg: shared types and constants of the dynamic range compressor
// Sequencer states, register indexes, reset values and fixed widths.
// ----------------------------------------------------------------------------
package drc_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int COEF_W      = 16;
    localparam int RATIO_W     = 17;
    localparam int THR_W       = 16;
    localparam int GAIN_W      = 16;
    localparam int QUOT_BITS   = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd3;

    localparam logic [THR_W-1:0]   THR_RESET     = 16'd16384;
    localparam logic [RATIO_W-1:0] RATIO_RESET   = 17'd16384;
    localparam logic [COEF_W-1:0]  ATTACK_RESET  = 16'd65400;
    localparam logic [COEF_W-1:0]  RELEASE_RESET = 16'd65522;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN = 16'd32768;
    localparam logic [COEF_W:0]    COEF_ONE   = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ENV,
        ST_MUL_LVL,
        ST_SUM,
        ST_CMP,
        ST_MUL_TGT,
        ST_TGT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_MUL_OUT,
        ST_SCALE,
        ST_OUT
    } t_state;

endpackage

### rtl/drc_div.sv
// ----------------------------------------------------------------------------
// drc_div: iterative restoring divider
// Produces QW quotient bits, one compare and subtract per cycle.
// ----------------------------------------------------------------------------
module drc_div #(
    parameter int NW = 34,
    parameter int DW = 17,
    parameter int QW = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    localparam int CW   = (NW > DW + QW - 1) ? NW : DW + QW - 1;
    localparam int CNTW = $clog2(QW + 1);

    logic [CW-1:0]   r_rem;
    logic [CW-1:0]   r_den;
    logic [QW-1:0]   r_quot;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic            ge;

    assign ge = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= CW'(i_num);
            r_den  <= CW'(i_den) << (QW - 1);
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_den;
            end
            r_den  <= r_den >> 1;
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// dynamic_range_compressor: peak-envelope audio compressor
// Envelope follower, gain computer and output scaling on one shared multiplier.
// ----------------------------------------------------------------------------
// One sample is taken at a time and yields one result item. A sample whose
// smoothed envelope stays at or below the threshold goes on from the envelope
// update to the output product and scaling; above the threshold the target
// product and the serial divider of 18 quotient bits that forms the gain come first. All four
// products share one registered 17 by SAMPLE_BITS multiplier. A finished
// result sits in an output register, so the next sample can be accepted while
// it waits to be taken. Configuration registers are written through a plain
// write port and should only change while the block is idle.
module dynamic_range_compressor #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [drc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [drc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    input  logic                                i_block_end,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_sample_out,
    output logic [drc_pkg::GAIN_W-1:0]          o_applied_gain,
    output logic                                o_block_end_out
);

    localparam int SB   = SAMPLE_BITS;
    localparam int PW   = SB + drc_pkg::RATIO_W;
    localparam int TW   = ((PW > 32) ? PW : 32) + 1;
    localparam int CMPW = (SB > drc_pkg::THR_W) ? SB : drc_pkg::THR_W;
    localparam int WW   = 2 * SB + 14;
    localparam int QW   = drc_pkg::QUOT_BITS;
    localparam logic [SB-1:0] MAG_MAX = SB'((1 << (SB - 1)) - 1);

    drc_pkg::t_state r_state;
    drc_pkg::t_state n_state;

    logic [drc_pkg::THR_W-1:0]   r_thr;
    logic [drc_pkg::RATIO_W-1:0] r_inv;
    logic [drc_pkg::COEF_W-1:0]  r_attack;
    logic [drc_pkg::COEF_W-1:0]  r_release;

    logic [SB-1:0]               r_env;
    logic [SB-1:0]               r_level;
    logic                        r_neg;
    logic                        r_blk;
    logic [drc_pkg::COEF_W-1:0]  r_coef;
    logic [PW-1:0]               r_prod;
    logic [PW-1:0]               r_acc;
    logic [SB-1:0]               r_diff;
    logic [TW-1:0]               r_num;
    logic [drc_pkg::GAIN_W-1:0]  r_gain;
    logic [SB-1:0]               r_mag;

    logic                        r_out_valid;
    logic signed [SB-1:0]        r_sample_out;
    logic [drc_pkg::GAIN_W-1:0]  r_gain_out;
    logic                        r_blk_out;

    logic [drc_pkg::RATIO_W-1:0] mul_a;
    logic [SB-1:0]               mul_b;
    logic                        div_start;
    logic                        div_done;
    logic [QW-1:0]               div_quot;
    logic                        in_ready;
    logic                        out_load;
    logic                        above;
    logic [SB-1:0]               in_level;
    logic [PW:0]                 env_sum;
    logic [CMPW-1:0]             env_diff;
    logic [WW-1:0]               scaled;
    logic [SB-1:0]               scaled_mag;
    logic                        gain_sat;

    assign in_level   = i_sample_in[SB-1] ? (~i_sample_in + 1'b1) : i_sample_in;
    assign env_sum    = {1'b0, r_acc} + {1'b0, r_prod};
    assign above      = CMPW'(r_env) > CMPW'(r_thr);
    assign env_diff   = CMPW'(r_env) - CMPW'(r_thr);
    assign scaled     = {r_prod[SB+14:0], {(SB-1){1'b0}}} - WW'(r_prod[SB+14:0]);
    assign scaled_mag = scaled[WW-1:SB+14];
    assign gain_sat   = div_quot[QW-1] | (div_quot[QW-2:0] > (QW-1)'(drc_pkg::UNITY_GAIN));

    drc_div #(
        .NW(TW),
        .DW(SB + 1),
        .QW(QW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_num),
        .i_den  ({r_env, 1'b0}),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            drc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = drc_pkg::ST_MUL_ENV;
                end
            end
            drc_pkg::ST_MUL_ENV:  n_state = drc_pkg::ST_MUL_LVL;
            drc_pkg::ST_MUL_LVL:  n_state = drc_pkg::ST_SUM;
            drc_pkg::ST_SUM:      n_state = drc_pkg::ST_CMP;
            drc_pkg::ST_CMP: begin
                n_state = above ? drc_pkg::ST_MUL_TGT : drc_pkg::ST_MUL_OUT;
            end
            drc_pkg::ST_MUL_TGT:  n_state = drc_pkg::ST_TGT;
            drc_pkg::ST_TGT:      n_state = drc_pkg::ST_DIV;
            drc_pkg::ST_DIV:      n_state = drc_pkg::ST_DIV_WAIT;
            drc_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = drc_pkg::ST_MUL_OUT;
                end
            end
            drc_pkg::ST_MUL_OUT:  n_state = drc_pkg::ST_SCALE;
            drc_pkg::ST_SCALE:    n_state = drc_pkg::ST_OUT;
            drc_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = drc_pkg::ST_IDLE;
                end
            end
            default:              n_state = drc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        in_ready  = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            drc_pkg::ST_IDLE: in_ready = 1'b1;
            drc_pkg::ST_MUL_ENV: begin
                mul_a = {1'b0, r_coef};
                mul_b = r_env;
            end
            drc_pkg::ST_MUL_LVL: begin
                mul_a = drc_pkg::COEF_ONE - {1'b0, r_coef};
                mul_b = r_level;
            end
            drc_pkg::ST_MUL_TGT: begin
                mul_a = r_inv;
                mul_b = r_diff;
            end
            drc_pkg::ST_DIV: div_start = 1'b1;
            drc_pkg::ST_MUL_OUT: begin
                mul_a = {1'b0, r_gain};
                mul_b = r_level;
            end
            drc_pkg::ST_OUT: out_load = !r_out_valid || i_out_ready;
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= drc_pkg::ST_IDLE;
            r_thr     <= drc_pkg::THR_RESET;
            r_inv     <= drc_pkg::RATIO_RESET;
            r_attack  <= drc_pkg::ATTACK_RESET;
            r_release <= drc_pkg::RELEASE_RESET;
            r_env     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    drc_pkg::CFG_THRESHOLD: r_thr     <= i_cfg_data[drc_pkg::THR_W-1:0];
                    drc_pkg::CFG_INV_RATIO: r_inv     <= i_cfg_data;
                    drc_pkg::CFG_ATTACK:    r_attack  <= i_cfg_data[drc_pkg::COEF_W-1:0];
                    drc_pkg::CFG_RELEASE:   r_release <= i_cfg_data[drc_pkg::COEF_W-1:0];
                    default: begin
                        r_thr <= r_thr;
                    end
                endcase
            end
            if (r_state == drc_pkg::ST_SUM) begin
                r_env <= env_sum[SB+15:16];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
        if (in_ready && i_in_valid) begin
            r_level <= in_level;
            r_neg   <= i_sample_in[SB-1];
            r_blk   <= i_block_end;
            r_coef  <= (in_level > r_env) ? r_attack : r_release;
        end
        if (r_state == drc_pkg::ST_MUL_LVL) begin
            r_acc <= r_prod;
        end
        if (r_state == drc_pkg::ST_CMP) begin
            r_diff <= env_diff[SB-1:0];
            if (!above) begin
                r_gain <= drc_pkg::UNITY_GAIN;
            end
        end
        if (r_state == drc_pkg::ST_TGT) begin
            r_num <= TW'({r_thr, 16'd0}) + TW'(r_prod);
        end
        if (r_state == drc_pkg::ST_DIV_WAIT && div_done) begin
            r_gain <= gain_sat ? drc_pkg::UNITY_GAIN : div_quot[drc_pkg::GAIN_W-1:0];
        end
        if (r_state == drc_pkg::ST_SCALE) begin
            r_mag <= (scaled_mag > MAG_MAX) ? MAG_MAX : scaled_mag;
        end
        if (out_load) begin
            r_sample_out <= r_neg ? (~r_mag + 1'b1) : r_mag;
            r_gain_out   <= r_gain;
            r_blk_out    <= r_blk;
        end
    end

    assign o_in_ready      = in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = r_sample_out;
    assign o_applied_gain  = r_gain_out;
    assign o_block_end_out = r_blk_out;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the dynamic range compressor
// A directed set of samples and register settings exercises the extremes and
// the corner cases of the gain computer. Random runs of loud, quiet and noisy
// samples follow under random register settings. A local envelope and gain
// model predicts every result, and each output item is compared field by
// field. Sender and receiver idle at random, and one long receiver hold-off
// backs the block up.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int RAND_CHUNKS   = 10;
    localparam int CHUNK_ITEMS   = 75;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               block_end;
    } t_sample_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [15:0]        gain;
        logic               block_end;
    } t_comp_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [drc_pkg::CFG_IDX_W-1:0]   i_cfg_index = drc_pkg::CFG_THRESHOLD;
    logic [drc_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic signed [15:0]              i_sample_in = '0;
    logic                            i_block_end = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic signed [15:0]              o_sample_out;
    logic [drc_pkg::GAIN_W-1:0]      o_applied_gain;
    logic                            o_block_end_out;

    dynamic_range_compressor #(
        .SAMPLE_BITS(16)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_in    (i_sample_in),
        .i_block_end    (i_block_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_out   (o_sample_out),
        .o_applied_gain (o_applied_gain),
        .o_block_end_out(o_block_end_out)
    );

    t_sample_item      sample_q[$];
    t_comp_result      result_q[$];

    longint unsigned   env_level = 0;
    longint unsigned   thr_level = drc_pkg::THR_RESET;
    longint unsigned   inv_ratio = drc_pkg::RATIO_RESET;
    longint unsigned   atk_coef = drc_pkg::ATTACK_RESET;
    longint unsigned   rel_coef = drc_pkg::RELEASE_RESET;

    int                n_queued = 0;
    int                n_accepted = 0;
    int                n_checked = 0;
    int                n_compressed = 0;
    int                n_settings = 1;
    int                err_cnt = 0;
    int                cycle_cnt = 0;
    int                send_idle_pct = 22;
    int                recv_idle_pct = 71;
    int                stall_requests = 0;
    int                stall_served = 0;
    int                hold_left = 0;
    logic              in_taken = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Envelope follower, gain computer and output scaling; updates the envelope copy.
    function automatic t_comp_result compress_sample(t_sample_item it);
        longint          sx;
        longint unsigned level;
        longint unsigned coef;
        longint unsigned tgt;
        longint unsigned g;
        longint unsigned mag;
        t_comp_result    r;
        sx = it.sample;
        level = (sx < 0) ? -sx : sx;
        coef = (level > env_level) ? atk_coef : rel_coef;
        env_level = (coef * env_level + (65536 - coef) * level) >> 16;
        if (env_level <= thr_level) begin
            g = drc_pkg::UNITY_GAIN;
        end else begin
            tgt = (thr_level << 16) + (env_level - thr_level) * inv_ratio;
            g = tgt / (env_level * 2);
            if (g > drc_pkg::UNITY_GAIN) begin
                g = drc_pkg::UNITY_GAIN;
            end
        end
        mag = (level * g * 32767) / (64'd32768 * 64'd32768);
        if (mag > 32767) begin
            mag = 32767;
        end
        r.sample = (sx < 0) ? 16'(0 - mag) : 16'(mag);
        r.gain = 16'(g);
        r.block_end = it.block_end;
        return r;
    endfunction

    task automatic queue_sample(logic signed [15:0] s, logic be);
        sample_q.push_back(t_sample_item'{sample: s, block_end: be});
        n_queued++;
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (n_accepted != n_queued || result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_regs(longint unsigned thr, longint unsigned inv,
                            longint unsigned atk, longint unsigned rel);
        logic [drc_pkg::CFG_IDX_W-1:0] idx_list[4];
        longint unsigned               val_list[4];
        idx_list = '{drc_pkg::CFG_THRESHOLD, drc_pkg::CFG_INV_RATIO,
                     drc_pkg::CFG_ATTACK, drc_pkg::CFG_RELEASE};
        val_list = '{thr, inv, atk, rel};
        wait_drained();
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx_list[i];
            i_cfg_data <= drc_pkg::CFG_DATA_W'(val_list[i]);
            case (idx_list[i])
                drc_pkg::CFG_THRESHOLD: thr_level = val_list[i] & 64'hFFFF;
                drc_pkg::CFG_INV_RATIO: inv_ratio = val_list[i] & 64'h1FFFF;
                drc_pkg::CFG_ATTACK:    atk_coef = val_list[i] & 64'hFFFF;
                drc_pkg::CFG_RELEASE:   rel_coef = val_list[i] & 64'hFFFF;
                default: ;
            endcase
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
        end
        n_settings++;
    endtask

    function automatic longint unsigned pick_coef();
        case ($urandom_range(4))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(65535, 60000);
            default: return $urandom_range(65535);
        endcase
    endfunction

    // Runs of loud, quiet, noisy or full-scale material so the envelope builds and decays.
    task automatic feed_random(int count);
        int              left;
        int              style;
        int              run_len;
        longint          mag;
        logic signed [15:0] s;
        left = count;
        while (left > 0) begin
            style = $urandom_range(3);
            run_len = $urandom_range(30, 4);
            if (run_len > left) begin
                run_len = left;
            end
            for (int i = 0; i < run_len; i++) begin
                case (style)
                    0: s = 16'($urandom);
                    1: begin
                        mag = $urandom_range(32768, 16000);
                        s = $urandom_range(1) ? 16'(-mag) : 16'(mag > 32767 ? 32767 : mag);
                    end
                    2: begin
                        mag = $urandom_range(600);
                        s = $urandom_range(1) ? 16'(-mag) : 16'(mag);
                    end
                    default: begin
                        case ($urandom_range(3))
                            0: s = -16'sd32768;
                            1: s = 16'sd32767;
                            2: s = -16'sd32767;
                            default: s = 16'($urandom_range(65535));
                        endcase
                    end
                endcase
                queue_sample(s, $urandom_range(7) == 0);
            end
            left -= run_len;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d items outstanding.",
                     cycle_cnt, result_q.size());
            $display("FAIL dynamic_range_compressor");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_comp_result r;
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            r = compress_sample(t_sample_item'{sample: i_sample_in, block_end: i_block_end});
            if (r.gain != drc_pkg::UNITY_GAIN) begin
                n_compressed++;
            end
            result_q.push_back(r);
            n_accepted++;
        end
    end

    always @(posedge i_clk) begin
        t_comp_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                $error("Unexpected output item: sample_out %0d, applied_gain %0d",
                       o_sample_out, o_applied_gain);
                err_cnt++;
            end else begin
                want = result_q.pop_front();
                n_checked++;
                if (o_sample_out !== want.sample) begin
                    $error("sample_out: expected %0d, got %0d", want.sample, o_sample_out);
                    err_cnt++;
                end
                if (o_applied_gain !== want.gain) begin
                    $error("applied_gain: expected %0d, got %0d", want.gain, o_applied_gain);
                    err_cnt++;
                end
                if (o_block_end_out !== want.block_end) begin
                    $error("block_end_out: expected %0d, got %0d",
                           want.block_end, o_block_end_out);
                    err_cnt++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        t_sample_item nxt;
        if (!i_in_valid || in_taken) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = sample_q.pop_front();
                i_in_valid <= 1'b1;
                i_sample_in <= nxt.sample;
                i_block_end <= nxt.block_end;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            hold_left = LONG_HOLD;
        end
        i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        if (hold_left > 0) begin
            hold_left--;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd32767, 1'b1);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(-16'sd32767, 1'b1);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd1, 1'b1);
        queue_sample(16'sd0, 1'b0);

        set_regs(0, 0, 0, 0);
        queue_sample(16'sd32767, 1'b0);
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(16'sd100, 1'b0);
        queue_sample(16'sd0, 1'b1);

        set_regs(8192, 131071, 0, 0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sd20000, 1'b0);
        queue_sample(16'sd5000, 1'b1);

        set_regs(65535, 0, 30000, 65535);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sd32767, 1'b1);
        queue_sample(-16'sd32768, 1'b0);

        set_regs(32768, 65536, 65535, 0);
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(16'sd32767, 1'b0);
        queue_sample(16'sd12345, 1'b1);
        queue_sample(-16'sd32768, 1'b0);

        for (int c = 0; c < RAND_CHUNKS; c++) begin
            case ($urandom_range(5))
                0: set_regs(0, $urandom_range(131071), pick_coef(), pick_coef());
                1: set_regs(32768, $urandom_range(65536), pick_coef(), pick_coef());
                2: set_regs(65535, 65536, pick_coef(), pick_coef());
                3: set_regs($urandom_range(32768), 0, pick_coef(), pick_coef());
                default: set_regs($urandom_range(32768), $urandom_range(65536),
                                  pick_coef(), pick_coef());
            endcase
            if (c == 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 22;
            end else if (c == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (c == 1) begin
                stall_requests++;
            end
            feed_random(CHUNK_ITEMS);
        end

        wait_drained();
        $display("Checked %0d of %0d items over %0d register settings.",
                 n_checked, n_queued, n_settings);
        $display("%0d results came out below unity gain.", n_compressed);
        if (err_cnt == 0) begin
            $display("PASS dynamic_range_compressor");
        end else begin
            $display("FAIL dynamic_range_compressor");
        end
        $finish;
    end

endmodule
